// File: src/rth_pkg.sv
// ----------------------------------------------------------------------------
// rth_pkg: shared types and constants for the RGB to HSV pixel converter
// Channel widths, divider geometry and the hue sector codes.
// ----------------------------------------------------------------------------
package rth_pkg;

   localparam int PIX_W       = 8;             // one color channel
   localparam int QUO_W       = 8;             // hue_half and saturation
   localparam int DIV_STEPS   = QUO_W;         // one quotient bit per stage
   localparam int DIFF_W      = PIX_W + 1;     // signed channel difference
   localparam int HUE_BASE_W  = PIX_W + 2;     // up to 4*delta
   localparam int HUE_SUM_W   = PIX_W + 4;     // base + difference, signed
   localparam int HUE_NUM_W   = PIX_W + 11;    // 60*sum and wrapped value, signed
   localparam int HUE_WRAP_W  = PIX_W + 9;     // 360*delta
   localparam int HUE_REM_W   = PIX_W + 9;     // non-negative hue numerator
   localparam int HUE_DIV_W   = PIX_W + 1;     // 2*delta
   localparam int SAT_REM_W   = 2 * PIX_W;     // 255*delta

   localparam int HUE_STEP_DEG = 60;
   localparam int HUE_FULL_DEG = 360;
   localparam int HUE_HALF_MAX = 179;

   typedef enum logic [1:0] {
      SECTOR_RED,
      SECTOR_GREEN,
      SECTOR_BLUE
   } sector_type;

endpackage

// File: src/rgb_to_hsv_pixel.sv
// ----------------------------------------------------------------------------
// rgb_to_hsv_pixel: pipelined 8-bit RGB to HSV pixel converter
// Max/min and sector pick, hue and saturation numerators, then two
// restoring dividers that retire one quotient bit per stage.
// ----------------------------------------------------------------------------
//
//   channel   direction   handshake               payload
//   req_      in          req_valid / req_stall   req_blue, req_green, req_red
//   rsp_      out         rsp_valid / rsp_stall   rsp_hue_half, rsp_saturation,
//                                                 rsp_brightness
//
// One item per clock sustained while rsp_stall stays low; ten register stages
// (max/min stage, numerator stage, eight divider bit stages).
// The divider stages set the depth: one compare-subtract per quotient bit.
// Reset (synchronous) clears all stage valid bits; no clearing pass.
// A stall on rsp_ holds the output; earlier stages keep filling bubbles,
// so req_stall rises only once every stage holds an item.
// ----------------------------------------------------------------------------
module rgb_to_hsv_pixel (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [rth_pkg::PIX_W-1:0]  req_blue,
   input  logic [rth_pkg::PIX_W-1:0]  req_green,
   input  logic [rth_pkg::PIX_W-1:0]  req_red,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [rth_pkg::QUO_W-1:0]  rsp_hue_half,
   output logic [rth_pkg::QUO_W-1:0]  rsp_saturation,
   output logic [rth_pkg::PIX_W-1:0]  rsp_brightness
);

   localparam int PIX_W      = rth_pkg::PIX_W;
   localparam int QUO_W      = rth_pkg::QUO_W;
   localparam int DIV_STEPS  = rth_pkg::DIV_STEPS;
   localparam int DIFF_W     = rth_pkg::DIFF_W;
   localparam int HUE_BASE_W = rth_pkg::HUE_BASE_W;
   localparam int HUE_SUM_W  = rth_pkg::HUE_SUM_W;
   localparam int HUE_NUM_W  = rth_pkg::HUE_NUM_W;
   localparam int HUE_WRAP_W = rth_pkg::HUE_WRAP_W;
   localparam int HUE_REM_W  = rth_pkg::HUE_REM_W;
   localparam int HUE_DIV_W  = rth_pkg::HUE_DIV_W;
   localparam int SAT_REM_W  = rth_pkg::SAT_REM_W;

   // ---------------- stage A: max, min, sector ----------------
   logic                       a_vld_ff;
   logic                       a_en;
   logic [PIX_W-1:0]           a_mx_in, a_mx_ff;
   logic [PIX_W-1:0]           a_mn;
   logic [PIX_W-1:0]           a_delta_in, a_delta_ff;
   rth_pkg::sector_type        a_sector_in, a_sector_ff;
   logic signed [DIFF_W-1:0]   a_diff_in, a_diff_ff;

   // ---------------- stage B and divider stages ----------------
   logic                       vld_ff [0:DIV_STEPS];
   logic                       en     [0:DIV_STEPS];
   logic [PIX_W-1:0]           mx_ff  [0:DIV_STEPS];
   logic [QUO_W-1:0]           sat_q_ff [0:DIV_STEPS];
   logic [QUO_W-1:0]           hue_q_ff [0:DIV_STEPS];
   logic [SAT_REM_W-1:0]       sat_rem_ff [0:DIV_STEPS-1];
   logic [PIX_W-1:0]           sat_div_ff [0:DIV_STEPS-1];
   logic [HUE_REM_W-1:0]       hue_rem_ff [0:DIV_STEPS-1];
   logic [HUE_DIV_W-1:0]       hue_div_ff [0:DIV_STEPS-1];

   logic [HUE_BASE_W-1:0]      hue_base;
   logic signed [HUE_SUM_W-1:0]  hue_sum;
   logic signed [HUE_NUM_W-1:0]  hue_num;
   logic signed [HUE_NUM_W-1:0]  hue_wrap;
   logic signed [HUE_NUM_W-1:0]  hue_adj;
   logic [HUE_REM_W-1:0]       b_hue_rem_in;
   logic [HUE_DIV_W-1:0]       b_hue_div_in;
   logic [SAT_REM_W-1:0]       b_sat_rem_in;
   logic [PIX_W-1:0]           b_sat_div_in;

   // Ready ripples back from the output; a stage loads when it is empty
   // or the stage after it moves.
   always_comb begin
      en[DIV_STEPS] = !vld_ff[DIV_STEPS] || !rsp_stall;
      for (int i = DIV_STEPS - 1; i >= 0; i--) begin
         en[i] = !vld_ff[i] || en[i+1];
      end
      a_en = !a_vld_ff || en[0];
   end

   assign req_stall = !a_en;

   // Ties: red beats green, green beats blue.
   always_comb begin
      a_mx_in = req_red;
      if (req_green > a_mx_in) a_mx_in = req_green;
      if (req_blue > a_mx_in)  a_mx_in = req_blue;
      a_mn = req_red;
      if (req_green < a_mn) a_mn = req_green;
      if (req_blue < a_mn)  a_mn = req_blue;
      a_delta_in = a_mx_in - a_mn;
      if (a_mx_in == req_red) begin
         a_sector_in = rth_pkg::SECTOR_RED;
         a_diff_in   = $signed({1'b0, req_green}) - $signed({1'b0, req_blue});
      end else if (a_mx_in == req_green) begin
         a_sector_in = rth_pkg::SECTOR_GREEN;
         a_diff_in   = $signed({1'b0, req_blue}) - $signed({1'b0, req_red});
      end else begin
         a_sector_in = rth_pkg::SECTOR_BLUE;
         a_diff_in   = $signed({1'b0, req_red}) - $signed({1'b0, req_green});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
      end else if (a_en) begin
         a_vld_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (a_en) begin
         a_mx_ff     <= a_mx_in;
         a_delta_ff  <= a_delta_in;
         a_sector_ff <= a_sector_in;
         a_diff_ff   <= a_diff_in;
      end
   end

   // Hue numerator 60*(2*sector*delta + diff), wrapped by 360*delta if negative.
   always_comb begin
      case (a_sector_ff)
         rth_pkg::SECTOR_RED:   hue_base = '0;
         rth_pkg::SECTOR_GREEN: hue_base = {1'b0, a_delta_ff, 1'b0};
         rth_pkg::SECTOR_BLUE:  hue_base = {a_delta_ff, 2'b00};
         default:               hue_base = '0;
      endcase
      hue_sum  = $signed({2'b00, hue_base}) + HUE_SUM_W'(a_diff_ff);
      hue_num  = HUE_NUM_W'(hue_sum) * HUE_NUM_W'(rth_pkg::HUE_STEP_DEG);
      hue_wrap = $signed({2'b00, HUE_WRAP_W'(a_delta_ff) *
                                 HUE_WRAP_W'(rth_pkg::HUE_FULL_DEG)});
      hue_adj  = hue_num[HUE_NUM_W-1] ? hue_num + hue_wrap : hue_num;
      b_hue_rem_in = hue_adj[HUE_REM_W-1:0];
      // Grey pixels have a zero numerator; a unit divisor gives hue 0.
      b_hue_div_in = (a_delta_ff == '0) ? HUE_DIV_W'(1) : {a_delta_ff, 1'b0};
      b_sat_rem_in = {a_delta_ff, {PIX_W{1'b0}}} - {{PIX_W{1'b0}}, a_delta_ff};
      b_sat_div_in = (a_mx_ff == '0) ? PIX_W'(1) : a_mx_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (en[0]) begin
         vld_ff[0] <= a_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         mx_ff[0]      <= a_mx_ff;
         sat_q_ff[0]   <= '0;
         hue_q_ff[0]   <= '0;
         sat_rem_ff[0] <= b_sat_rem_in;
         sat_div_ff[0] <= b_sat_div_in;
         hue_rem_ff[0] <= b_hue_rem_in;
         hue_div_ff[0] <= b_hue_div_in;
      end
   end

   // Restoring division, most significant quotient bit first.
   for (genvar i = 1; i <= DIV_STEPS; i++) begin : g_div
      localparam int Shift = DIV_STEPS - i;

      logic [SAT_REM_W:0] sat_sub;
      logic [HUE_REM_W:0] hue_sub;
      logic               sat_take;
      logic               hue_take;

      assign sat_sub  = {1'b0, sat_rem_ff[i-1]} -
                        ((SAT_REM_W+1)'(sat_div_ff[i-1]) << Shift);
      assign hue_sub  = {1'b0, hue_rem_ff[i-1]} -
                        ((HUE_REM_W+1)'(hue_div_ff[i-1]) << Shift);
      assign sat_take = !sat_sub[SAT_REM_W];
      assign hue_take = !hue_sub[HUE_REM_W];

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i] <= 1'b0;
         end else if (en[i]) begin
            vld_ff[i] <= vld_ff[i-1];
         end
      end

      always_ff @(posedge clock) begin
         if (en[i]) begin
            mx_ff[i]    <= mx_ff[i-1];
            sat_q_ff[i] <= sat_q_ff[i-1] | (QUO_W'(sat_take) << Shift);
            hue_q_ff[i] <= hue_q_ff[i-1] | (QUO_W'(hue_take) << Shift);
         end
      end

      if (i < DIV_STEPS) begin : g_rem
         always_ff @(posedge clock) begin
            if (en[i]) begin
               sat_rem_ff[i] <= sat_take ? sat_sub[SAT_REM_W-1:0] : sat_rem_ff[i-1];
               hue_rem_ff[i] <= hue_take ? hue_sub[HUE_REM_W-1:0] : hue_rem_ff[i-1];
               sat_div_ff[i] <= sat_div_ff[i-1];
               hue_div_ff[i] <= hue_div_ff[i-1];
            end
         end
      end
   end

   assign rsp_valid      = vld_ff[DIV_STEPS];
   assign rsp_hue_half   = hue_q_ff[DIV_STEPS];
   assign rsp_saturation = sat_q_ff[DIV_STEPS];
   assign rsp_brightness = mx_ff[DIV_STEPS];

endmodule

// File: src/rth_port_checker.sv
// ----------------------------------------------------------------------------
// rth_port_checker: port-level checks for the RGB to HSV pixel converter
// Watches the result channel, input stalls and the value ranges of each item.
// ----------------------------------------------------------------------------
module rth_port_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_stall,
   input logic                       rsp_valid,
   input logic                       rsp_stall,
   input logic [rth_pkg::QUO_W-1:0]  rsp_hue_half,
   input logic [rth_pkg::QUO_W-1:0]  rsp_saturation,
   input logic [rth_pkg::PIX_W-1:0]  rsp_brightness
);

   // Hold a stalled item.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("stalled item dropped");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=>
         $stable(rsp_hue_half) && $stable(rsp_saturation) && $stable(rsp_brightness))
      else $error("stalled item changed");

   // The input only backs up behind a stalled result.
   a_req_stall: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled while output free");

   a_hue_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_hue_half <= rth_pkg::QUO_W'(rth_pkg::HUE_HALF_MAX))
      else $error("hue out of range");

   // A black pixel has no saturation and no hue.
   a_black: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_brightness == '0 |-> rsp_saturation == '0 && rsp_hue_half == '0)
      else $error("black pixel with hue or saturation");

endmodule

bind rgb_to_hsv_pixel rth_port_checker u_port_checker (.*);

// File: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench for the rgb_to_hsv_pixel converter
// Drives pixels through the req_ channel and predicts hue, saturation and
// value for each accepted item. A checker compares every rsp_ item against
// the oldest prediction. The sender idles in bursts and the receiver stalls
// on changing patterns, with one long receiver hold and one full drain.
// ----------------------------------------------------------------------------
module tb_top;

   typedef struct packed {
      logic [rth_pkg::QUO_W-1:0] hue_half;
      logic [rth_pkg::QUO_W-1:0] saturation;
      logic [rth_pkg::PIX_W-1:0] brightness;
   } hsv_type;

   typedef enum int {
      RX_FREE,
      RX_LIGHT,
      RX_HEAVY,
      RX_PERIODIC
   } rx_pattern_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic [rth_pkg::PIX_W-1:0] req_blue = '0;
   logic [rth_pkg::PIX_W-1:0] req_green = '0;
   logic [rth_pkg::PIX_W-1:0] req_red = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic [rth_pkg::QUO_W-1:0] rsp_hue_half;
   logic [rth_pkg::QUO_W-1:0] rsp_saturation;
   logic [rth_pkg::PIX_W-1:0] rsp_brightness;

   hsv_type        pending_hsv[$];
   int             error_count = 0;
   rx_pattern_type rx_pattern = RX_FREE;
   int             rx_hold_request = 0;
   bit             tx_bursty = 1'b0;
   int             tx_burst_left = 0;

   rgb_to_hsv_pixel u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_blue       (req_blue),
      .req_green      (req_green),
      .req_red        (req_red),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_hue_half   (rsp_hue_half),
      .rsp_saturation (rsp_saturation),
      .rsp_brightness (rsp_brightness)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Hue, saturation and value of one pixel in exact integer arithmetic.
   function automatic hsv_type convert_pixel(input logic [rth_pkg::PIX_W-1:0] b,
                                             input logic [rth_pkg::PIX_W-1:0] g,
                                             input logic [rth_pkg::PIX_W-1:0] r);
      int                  mx;
      int                  mn;
      int                  delta;
      int                  base;
      int                  diff;
      int                  num;
      int                  hue;
      int                  sat;
      rth_pkg::sector_type sector;
      hsv_type             res;
      mx = int'(r);
      sector = rth_pkg::SECTOR_RED;
      // strict compares give red the win on ties, then green
      if (int'(g) > mx) begin
         mx = int'(g);
         sector = rth_pkg::SECTOR_GREEN;
      end
      if (int'(b) > mx) begin
         mx = int'(b);
         sector = rth_pkg::SECTOR_BLUE;
      end
      mn = int'(r);
      if (int'(g) < mn) mn = int'(g);
      if (int'(b) < mn) mn = int'(b);
      delta = mx - mn;
      sat = (mx != 0) ? (255 * delta) / mx : 0;
      hue = 0;
      if (delta != 0) begin
         case (sector)
            rth_pkg::SECTOR_RED: begin
               base = 0;
               diff = int'(g) - int'(b);
            end
            rth_pkg::SECTOR_GREEN: begin
               base = 2;
               diff = int'(b) - int'(r);
            end
            default: begin
               base = 4;
               diff = int'(r) - int'(g);
            end
         endcase
         num = rth_pkg::HUE_STEP_DEG * (base * delta + diff);
         if (num < 0) num = num + rth_pkg::HUE_FULL_DEG * delta;
         hue = num / (2 * delta);
      end
      res.hue_half = rth_pkg::QUO_W'(hue);
      res.saturation = rth_pkg::QUO_W'(sat);
      res.brightness = rth_pkg::PIX_W'(mx);
      return res;
   endfunction

   // Record accepted pixels and check each accepted result.
   always @(posedge clock) begin
      hsv_type want;
      if (!reset) begin
         if (req_valid && !req_stall)
            pending_hsv = {pending_hsv, convert_pixel(req_blue, req_green, req_red)};
         if (rsp_valid && !rsp_stall) begin
            if (pending_hsv.size() == 0) begin
               $display("%0t: unexpected item hue_half %0d saturation %0d brightness %0d",
                        $time, rsp_hue_half, rsp_saturation, rsp_brightness);
               error_count++;
            end else begin
               want = pending_hsv.pop_front();
               if (rsp_hue_half !== want.hue_half) begin
                  $display("%0t: hue_half expected %0d actual %0d",
                           $time, want.hue_half, rsp_hue_half);
                  error_count++;
               end
               if (rsp_saturation !== want.saturation) begin
                  $display("%0t: saturation expected %0d actual %0d",
                           $time, want.saturation, rsp_saturation);
                  error_count++;
               end
               if (rsp_brightness !== want.brightness) begin
                  $display("%0t: brightness expected %0d actual %0d",
                           $time, want.brightness, rsp_brightness);
                  error_count++;
               end
            end
         end
      end
   end

   // Receiver stall pattern; a hold request pins stall high until it counts down.
   always @(posedge clock) begin
      int unsigned hold_left;
      int unsigned phase;
      if (rx_hold_request > 0) begin
         hold_left = rx_hold_request;
         rx_hold_request = 0;
      end
      phase++;
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         case (rx_pattern)
            RX_FREE:     rsp_stall <= 1'b0;
            RX_LIGHT:    rsp_stall <= ($urandom_range(0, 3) == 0);
            RX_HEAVY:    rsp_stall <= ($urandom_range(0, 3) != 0);
            RX_PERIODIC: rsp_stall <= ((phase % 7) < 2);
            default:     rsp_stall <= 1'b0;
         endcase
      end
   end

   // Offer one pixel and wait for the edge that accepts it.
   task automatic send_pixel(input logic [rth_pkg::PIX_W-1:0] b,
                             input logic [rth_pkg::PIX_W-1:0] g,
                             input logic [rth_pkg::PIX_W-1:0] r);
      int gap;
      req_valid <= 1'b1;
      req_blue <= b;
      req_green <= g;
      req_red <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      // idle between bursts
      if (tx_bursty) begin
         if (tx_burst_left == 0) begin
            tx_burst_left = $urandom_range(1, 16);
            gap = $urandom_range(1, 8);
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         tx_burst_left--;
      end
   endtask

   task automatic stop_sending();
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic wait_drained();
      while (pending_hsv.size() != 0) @(posedge clock);
   endtask

   task automatic test_directed();
      tx_bursty = 1'b0;
      rx_pattern = RX_FREE;
      // black, white and grey
      send_pixel(8'd0, 8'd0, 8'd0);
      send_pixel(8'd255, 8'd255, 8'd255);
      send_pixel(8'd128, 8'd128, 8'd128);
      send_pixel(8'd1, 8'd1, 8'd1);
      // pure primaries
      send_pixel(8'd0, 8'd0, 8'd255);
      send_pixel(8'd0, 8'd255, 8'd0);
      send_pixel(8'd255, 8'd0, 8'd0);
      // ties for the maximum
      send_pixel(8'd0, 8'd255, 8'd255);
      send_pixel(8'd255, 8'd255, 8'd0);
      send_pixel(8'd255, 8'd0, 8'd255);
      send_pixel(8'd7, 8'd200, 8'd200);
      // red maximum with negative hue, wrapped by a full turn
      send_pixel(8'd100, 8'd0, 8'd255);
      send_pixel(8'd1, 8'd0, 8'd255);
      send_pixel(8'd255, 8'd254, 8'd255);
      // smallest nonzero deltas and single bits
      send_pixel(8'd0, 8'd0, 8'd1);
      send_pixel(8'd1, 8'd0, 8'd0);
      send_pixel(8'd0, 8'd1, 8'd0);
      send_pixel(8'd1, 8'd2, 8'd3);
      send_pixel(8'd254, 8'd255, 8'd253);
      // alternating bit patterns
      send_pixel(8'hAA, 8'h55, 8'hFF);
      send_pixel(8'h55, 8'hAA, 8'h00);
      send_pixel(8'h80, 8'h7F, 8'h01);
      stop_sending();
   endtask

   // Channel near zero or near full scale.
   function automatic logic [rth_pkg::PIX_W-1:0] edge_level();
      int lvl;
      lvl = ($urandom_range(0, 1) != 0) ? 255 - int'($urandom_range(0, 1))
                                        : int'($urandom_range(0, 1));
      return rth_pkg::PIX_W'(lvl);
   endfunction

   task automatic send_random_pixel();
      logic [rth_pkg::PIX_W-1:0] b;
      logic [rth_pkg::PIX_W-1:0] g;
      logic [rth_pkg::PIX_W-1:0] r;
      logic [rth_pkg::PIX_W-1:0] v;
      b = rth_pkg::PIX_W'($urandom);
      g = rth_pkg::PIX_W'($urandom);
      r = rth_pkg::PIX_W'($urandom);
      v = rth_pkg::PIX_W'($urandom);
      case ($urandom_range(0, 9))
         6: begin
            // two channels share the maximum
            case ($urandom_range(0, 2))
               0: begin
                  r = v;
                  g = v;
                  b = rth_pkg::PIX_W'($urandom_range(0, v));
               end
               1: begin
                  g = v;
                  b = v;
                  r = rth_pkg::PIX_W'($urandom_range(0, v));
               end
               default: begin
                  r = v;
                  b = v;
                  g = rth_pkg::PIX_W'($urandom_range(0, v));
               end
            endcase
         end
         7: begin
            b = v;
            g = v;
            r = v;
         end
         8: begin
            b = rth_pkg::PIX_W'($urandom_range(0, 3));
            g = rth_pkg::PIX_W'($urandom_range(0, 3));
            r = rth_pkg::PIX_W'($urandom_range(0, 3));
         end
         9: begin
            b = edge_level();
            g = edge_level();
            r = edge_level();
         end
         default: ;
      endcase
      send_pixel(b, g, r);
   endtask

   task automatic test_random(input int count);
      for (int i = 0; i < count; i++) begin
         if (i % 150 == 0) begin
            rx_pattern = rx_pattern_type'($urandom_range(0, 3));
            tx_bursty = ($urandom_range(0, 3) != 0);
            tx_burst_left = 0;
         end
         send_random_pixel();
      end
      stop_sending();
   endtask

   // Hold the receiver off while the sender keeps offering items back to back.
   task automatic test_backpressure();
      tx_bursty = 1'b0;
      rx_pattern = RX_FREE;
      rx_hold_request = 80;
      repeat (40) send_random_pixel();
      rx_pattern = RX_LIGHT;
      repeat (20) send_random_pixel();
      stop_sending();
   endtask

   // Pause until every pixel in flight has come out, then resume.
   task automatic test_drain_pause();
      tx_bursty = 1'b1;
      tx_burst_left = 0;
      rx_pattern = RX_PERIODIC;
      repeat (30) send_random_pixel();
      stop_sending();
      wait_drained();
      @(posedge clock);
      repeat (30) send_random_pixel();
      stop_sending();
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_backpressure();
      test_random(700);
      test_drain_pause();
      test_random(650);
      rx_pattern = RX_FREE;
      wait_drained();
      repeat (20) @(posedge clock);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

// File: filelist.f
src/rth_pkg.sv
src/rgb_to_hsv_pixel.sv
src/rth_port_checker.sv
sim/tb_top.sv
